FILE: src/scpc_pkg.sv
// ============================================================================
// scpc_pkg
// Shared types and constants for the sampler channel playback controller:
// event and result beats, configuration record, codes and fixed sizes.
// ============================================================================
package scpc_pkg;

    // Fixed sizes
    localparam int BLOCK_FRAMES  = 4096;
    localparam int POSITION_BITS = 24;
    localparam int FRAME_W       = 12;
    localparam int POS_W         = 24;
    localparam int VOL_W         = 16;
    localparam int VEL_W         = 7;

    // Frame wrap within one block (block length is a power of two)
    localparam logic [FRAME_W-1:0] FRAME_MASK = FRAME_W'(BLOCK_FRAMES - 1);
    // Play position bits kept from sample begin
    localparam logic [POS_W-1:0] POS_MASK = POS_W'((64'd1 << POSITION_BITS) - 64'd1);

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_PLAY_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VEL_SETS_VOL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_ON_HALT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REC_AS_LOOPS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_BEGIN   = 3'd4;

    // Play modes; the upper half are loop modes
    typedef enum logic [2:0] {
        MODE_SINGLE_BASIC   = 3'd0,
        MODE_SINGLE_PRESS   = 3'd1,
        MODE_SINGLE_RETRIG  = 3'd2,
        MODE_SINGLE_ENDLESS = 3'd3,
        MODE_LOOP_BASIC     = 3'd4,
        MODE_LOOP_ONCE      = 3'd5,
        MODE_LOOP_REPEAT    = 3'd6,
        MODE_LOOP_ONCE_BAR  = 3'd7
    } t_play_mode;

    // Play status
    typedef enum logic [1:0] {
        ST_OFF    = 2'd0,
        ST_PLAY   = 2'd1,
        ST_WAIT   = 2'd2,
        ST_ENDING = 2'd3
    } t_status;

    // Event operations
    typedef enum logic [3:0] {
        OP_PRESS      = 4'd0,
        OP_RELEASE    = 4'd1,
        OP_KILL       = 4'd2,
        OP_FIRST_BEAT = 4'd3,
        OP_BAR        = 4'd4,
        OP_SEQ_STOP   = 4'd5,
        OP_REC_ON     = 4'd6,
        OP_REC_OFF    = 4'd7,
        OP_REC_KILL   = 4'd8,
        OP_TOGGLE     = 4'd9,
        OP_LAST_FRAME = 4'd10,
        OP_QUANT_FIRE = 4'd11
    } t_op;

    // Configuration record
    typedef struct packed {
        t_play_mode       play_mode;
        logic             velocity_sets_volume;
        logic             stop_on_sequencer_halt;
        logic             recordings_as_loops;
        logic [POS_W-1:0] sample_begin;
    } t_cfg;

    // Input event beat
    typedef struct packed {
        logic [3:0]         operation;
        logic [FRAME_W-1:0] frame_delta;
        logic [VEL_W-1:0]   velocity;
        logic               clock_running;
        logic               can_quantize;
        logic               reading_actions;
        logic               recording_playing;
    } t_in_item;

    // Result beat
    typedef struct packed {
        logic [1:0]         play_status;
        logic [FRAME_W-1:0] start_offset;
        logic               rewind_pending;
        logic               position_reset;
        logic [POS_W-1:0]   reset_position;
        logic               volume_valid;
        logic [VOL_W-1:0]   volume;
        logic               clear_buffer;
        logic [FRAME_W-1:0] clear_from;
    } t_out_item;

endpackage

FILE: src/scpc_cfg_regs.sv
// ============================================================================
// scpc_cfg_regs
// Configuration register file. Takes one register write per beat and
// presents the settings as one record.
// ============================================================================
module scpc_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic [scpc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [scpc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic                              o_cfg_ready,
    output scpc_pkg::t_cfg                    o_cfg
);
    import scpc_pkg::*;

    t_cfg r_cfg;

    // always able to take a write
    assign o_cfg_ready = 1'b1;

    // register writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.play_mode              <= MODE_SINGLE_BASIC;
            r_cfg.velocity_sets_volume   <= 1'b0;
            r_cfg.stop_on_sequencer_halt <= 1'b1;
            r_cfg.recordings_as_loops    <= 1'b0;
            r_cfg.sample_begin           <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_PLAY_MODE:    r_cfg.play_mode <= t_play_mode'(i_cfg_data[2:0]);
                CFG_VEL_SETS_VOL: r_cfg.velocity_sets_volume <= i_cfg_data[0];
                CFG_STOP_ON_HALT: r_cfg.stop_on_sequencer_halt <= i_cfg_data[0];
                CFG_REC_AS_LOOPS: r_cfg.recordings_as_loops <= i_cfg_data[0];
                CFG_SAMPLE_BEGIN: r_cfg.sample_begin <= i_cfg_data[POS_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: src/scpc_event_core.sv
// ============================================================================
// scpc_event_core
// Channel play state (status, start offset, pending quantized action) and
// the single-pass event logic that updates it and forms the result beat.
// ============================================================================
module scpc_event_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  scpc_pkg::t_in_item   i_item,
    input  scpc_pkg::t_cfg       i_cfg,
    output scpc_pkg::t_out_item  o_result
);
    import scpc_pkg::*;

    typedef enum logic [1:0] {
        PA_NONE   = 2'd0,
        PA_PLAY   = 2'd1,
        PA_REWIND = 2'd2
    } t_pending;

    t_status            r_status,  n_status;
    logic [FRAME_W-1:0] r_offset,  n_offset;
    t_pending           r_pending, n_pending;

    // floor(vel * 32768 / 127): 32768 = 127 * 258 + 2
    function automatic logic [VOL_W-1:0] vel_to_volume(input logic [VEL_W-1:0] vel);
        logic [VEL_W:0]   twice;
        logic [VOL_W-1:0] base;
        logic [1:0]       corr;
        twice = {vel, 1'b0};
        base  = VOL_W'({9'd0, vel} * 16'd258);
        if (twice >= 8'd254) begin
            corr = 2'd2;
        end else if (twice >= 8'd127) begin
            corr = 2'd1;
        end else begin
            corr = 2'd0;
        end
        return base + VOL_W'(corr);
    endfunction

    // event decode and state update
    always_comb begin
        logic [FRAME_W-1:0] frame;
        logic               is_loop;
        logic               rec_ok;
        logic               press_en;
        logic               manual;
        logic               release_en;
        logic               kill_en;
        logic [VEL_W-1:0]   vel;
        logic               rew;
        logic               pos_reset;
        logic               vol_valid;
        logic [VOL_W-1:0]   volume;
        logic               clr;
        logic [FRAME_W-1:0] clr_from;

        frame      = i_item.frame_delta & FRAME_MASK;
        is_loop    = i_cfg.play_mode[2];
        rec_ok     = i_item.reading_actions && !is_loop;
        manual     = (i_item.operation == OP_PRESS);
        press_en   = manual || (i_item.operation == OP_REC_ON && rec_ok);
        release_en = (i_item.operation == OP_RELEASE) ||
                     (i_item.operation == OP_REC_OFF && rec_ok);
        kill_en    = (i_item.operation == OP_KILL) ||
                     (i_item.operation == OP_REC_KILL && rec_ok);
        vel        = manual ? i_item.velocity : 7'd127;

        n_status  = r_status;
        n_offset  = r_offset;
        n_pending = r_pending;
        rew       = 1'b0;
        pos_reset = 1'b0;
        vol_valid = 1'b0;
        volume    = '0;
        clr       = 1'b0;
        clr_from  = '0;

        if (press_en) begin
            case (r_status)
                ST_OFF: begin
                    n_offset = frame;
                    if (is_loop) begin
                        n_status = ST_WAIT;
                    end else begin
                        if (i_cfg.velocity_sets_volume) begin
                            vol_valid = 1'b1;
                            volume    = vel_to_volume(vel);
                        end
                        if (i_item.can_quantize && manual) begin
                            n_pending = PA_PLAY;
                        end else begin
                            n_status = ST_PLAY;
                        end
                    end
                end
                ST_PLAY: begin
                    if (i_cfg.play_mode == MODE_SINGLE_RETRIG) begin
                        if (i_item.can_quantize && manual) begin
                            n_pending = PA_REWIND;
                        end else begin
                            // rewind of a playing channel
                            n_pending = PA_NONE;
                            rew       = 1'b1;
                            n_offset  = frame;
                        end
                        n_status = ST_PLAY;
                    end else if (is_loop || i_cfg.play_mode == MODE_SINGLE_ENDLESS) begin
                        n_status = ST_ENDING;
                    end else begin
                        if (i_cfg.play_mode == MODE_SINGLE_BASIC) begin
                            n_pending = PA_NONE;
                            rew       = 1'b1;
                            n_offset  = frame;
                        end
                        n_status = ST_OFF;
                    end
                end
                ST_WAIT: n_status = ST_OFF;
                default: n_status = ST_PLAY;
            endcase
        end else if (release_en) begin
            if (i_cfg.play_mode == MODE_SINGLE_PRESS) begin
                if (r_status == ST_PLAY) begin
                    n_status  = ST_OFF;
                    pos_reset = 1'b1;
                    clr       = (frame != '0);
                    clr_from  = frame;
                end else begin
                    n_pending = PA_NONE;
                end
            end
        end else if (kill_en) begin
            n_status  = ST_OFF;
            pos_reset = 1'b1;
            clr       = (frame != '0);
            clr_from  = frame;
        end else begin
            case (i_item.operation)
                OP_FIRST_BEAT: begin
                    if (i_item.clock_running) begin
                        if (r_status == ST_PLAY) begin
                            if (is_loop) begin
                                n_pending = PA_NONE;
                                rew       = 1'b1;
                                n_offset  = frame;
                            end
                        end else if (r_status == ST_WAIT) begin
                            n_offset = frame;
                            n_status = ST_PLAY;
                        end else if (r_status == ST_ENDING) begin
                            if (is_loop) begin
                                n_status  = ST_OFF;
                                pos_reset = 1'b1;
                                clr       = (frame != '0);
                                clr_from  = frame;
                            end
                        end
                    end
                end
                OP_BAR: begin
                    if (r_status == ST_PLAY && i_cfg.play_mode == MODE_LOOP_REPEAT) begin
                        n_pending = PA_NONE;
                        rew       = 1'b1;
                        n_offset  = frame;
                    end else if (r_status == ST_WAIT &&
                                 i_cfg.play_mode == MODE_LOOP_ONCE_BAR) begin
                        n_status = ST_PLAY;
                        n_offset = frame;
                    end
                end
                OP_SEQ_STOP: begin
                    if (r_status == ST_WAIT) begin
                        if (is_loop) begin
                            n_status = ST_OFF;
                        end
                    end else if (r_status == ST_PLAY) begin
                        if (i_cfg.stop_on_sequencer_halt &&
                            (is_loop || i_item.reading_actions)) begin
                            // kill at block start: nothing to clear
                            n_status  = ST_OFF;
                            pos_reset = 1'b1;
                        end
                    end
                end
                OP_TOGGLE: begin
                    if (i_item.clock_running && i_item.recording_playing &&
                        !i_cfg.recordings_as_loops) begin
                        n_status  = ST_OFF;
                        pos_reset = 1'b1;
                    end
                end
                OP_LAST_FRAME: begin
                    if (r_status == ST_PLAY) begin
                        if (i_cfg.play_mode == MODE_SINGLE_BASIC ||
                            i_cfg.play_mode == MODE_SINGLE_PRESS ||
                            i_cfg.play_mode == MODE_SINGLE_RETRIG ||
                            (is_loop && !i_item.clock_running)) begin
                            n_status = ST_OFF;
                        end else if (i_cfg.play_mode == MODE_LOOP_ONCE ||
                                     i_cfg.play_mode == MODE_LOOP_ONCE_BAR) begin
                            n_status = ST_WAIT;
                        end
                    end else if (r_status == ST_ENDING) begin
                        if (i_cfg.play_mode == MODE_LOOP_ONCE ||
                            i_cfg.play_mode == MODE_LOOP_ONCE_BAR) begin
                            n_status = ST_WAIT;
                        end else begin
                            n_status = ST_OFF;
                        end
                    end
                end
                OP_QUANT_FIRE: begin
                    case (r_pending)
                        PA_PLAY: begin
                            n_pending = PA_NONE;
                            n_offset  = frame;
                            n_status  = ST_PLAY;
                        end
                        PA_REWIND: begin
                            n_pending = PA_NONE;
                            if (r_status == ST_PLAY || r_status == ST_ENDING) begin
                                rew      = 1'b1;
                                n_offset = frame;
                            end else begin
                                pos_reset = 1'b1;
                            end
                        end
                        default: n_pending = PA_NONE;
                    endcase
                end
                default: ;
            endcase
        end

        // result beat
        o_result.play_status    = n_status;
        o_result.start_offset   = n_offset;
        o_result.rewind_pending = rew;
        o_result.position_reset = pos_reset;
        o_result.reset_position = pos_reset ? (i_cfg.sample_begin & POS_MASK) : '0;
        o_result.volume_valid   = vol_valid;
        o_result.volume         = volume;
        o_result.clear_buffer   = clr;
        o_result.clear_from     = clr ? clr_from : '0;
    end

    // play state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status  <= ST_OFF;
            r_offset  <= '0;
            r_pending <= PA_NONE;
        end else if (i_step) begin
            r_status  <= n_status;
            r_offset  <= n_offset;
            r_pending <= n_pending;
        end
    end

endmodule

FILE: src/sample_channel_play_control_core.sv
// ============================================================================
// sample_channel_play_control_core
// Playback controller for one sampler channel: event beats in, one result
// beat out per event.
// ============================================================================
// Usage:
//   Event channel: i_in_valid / i_in_data / o_in_stall. A beat is taken on
//   a rising edge with valid high and stall low.
//   Result channel: o_out_valid / o_out_data / i_out_stall, same rule.
//   Every event gives exactly one result beat, in order.
//   Config channel: i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data;
//   write registers only while no event is in flight.
//   Path: an accepted event goes through the input register, one pass of
//   event logic and the result register.
//   Throughput: one event per cycle while i_out_stall is low; the event
//   logic is one combinational pass between the input and result registers.
//   Stall: while the result register holds a beat under i_out_stall, one
//   more event may sit in the input register; after that o_in_stall rises.
//   Reset (i_rst_n low, synchronous): both registers empty, channel off,
//   offset 0, no pending action, configuration at its reset values.
// ============================================================================
module sample_channel_play_control_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  scpc_pkg::t_in_item                i_in_data,
    output logic                              o_in_stall,
    output logic                              o_out_valid,
    output scpc_pkg::t_out_item               o_out_data,
    input  logic                              i_out_stall,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [scpc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [scpc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import scpc_pkg::*;

    t_cfg      w_cfg;
    t_out_item w_result;

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    logic      w_advance;

    // configuration registers
    scpc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (w_cfg)
    );

    // event logic and channel state
    scpc_event_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_advance),
        .i_item   (r_in),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    // move the held event into the result register when it has room
    assign w_advance  = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: src/scpc_checker.sv
// ============================================================================
// scpc_checker
// Port-level checks for the channel playback controller, bound to the top.
// ============================================================================
module scpc_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              o_out_valid,
    input  scpc_pkg::t_out_item               o_out_data,
    input  logic                              i_out_stall
);
    import scpc_pkg::*;

    // nothing comes out in the cycle after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat right after reset");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result beat changed");

    // a buffer clear only comes with a kill, which turns the channel off
    a_clear_kill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.clear_buffer |->
            o_out_data.position_reset && o_out_data.play_status == ST_OFF &&
            o_out_data.clear_from != '0)
        else $error("buffer clear without kill");

    // side-effect values are zero unless flagged
    a_side_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_out_data.position_reset || o_out_data.reset_position == '0) &&
            (o_out_data.volume_valid || o_out_data.volume == '0) &&
            (o_out_data.clear_buffer || o_out_data.clear_from == '0))
        else $error("unflagged side-effect value");

    // volume never exceeds unity
    a_vol_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.volume_valid |-> o_out_data.volume <= 16'd32768)
        else $error("volume above unity");

endmodule

bind sample_channel_play_control_core scpc_checker u_scpc_checker (.*);

FILE: verif/tb_sample_channel_play_control_core.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_sample_channel_play_control_core
// Self-checking bench for the sampler channel playback controller. A queue
// of commands (event beats, register writes, drain points) feeds a clocked
// driver. Each accepted event runs through a local model of the channel
// state, and the predicted result beat is queued. A clocked monitor stalls
// at random and compares every result beat field by field.
// ============================================================================
module tb_sample_channel_play_control_core;
    import scpc_pkg::*;

    // Pending quantized action codes
    localparam logic [1:0] PEND_NONE   = 2'd0;
    localparam logic [1:0] PEND_PLAY   = 2'd1;
    localparam logic [1:0] PEND_REWIND = 2'd2;

    // Idle cycles required before a register write
    localparam int CFG_SETTLE = 3;

    typedef enum logic [1:0] {
        CMD_EVENT,
        CMD_CFG,
        CMD_DRAIN
    } t_cmd_kind;

    typedef struct {
        t_cmd_kind             kind;
        t_in_item              beat;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } t_cmd;

    // DUT connections
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    t_in_item              i_in_data = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_out_item             o_out_data;
    logic                  i_out_stall = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    sample_channel_play_control_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    t_cmd      cmd_q[$];
    t_out_item predicted_beats[$];
    int        err_count = 0;

    // ------------------------------------------------------------------
    // Channel model: configuration, state and per-event side effects
    // ------------------------------------------------------------------
    t_play_mode         m_mode = MODE_SINGLE_BASIC;
    logic               m_vel_vol = 1'b0;
    logic               m_stop_halt = 1'b1;
    logic               m_rec_loops = 1'b0;
    logic [POS_W-1:0]   m_begin = '0;

    t_status            ch_status = ST_OFF;
    logic [FRAME_W-1:0] ch_offset = '0;
    logic               ch_rewind = 1'b0;
    logic [1:0]         ch_pending = PEND_NONE;

    logic               fx_pos_reset;
    logic               fx_vol_valid;
    logic [VOL_W-1:0]   fx_volume;
    logic               fx_clear;
    logic [FRAME_W-1:0] fx_clear_from;

    function automatic logic is_loop_mode();
        return m_mode >= MODE_LOOP_BASIC;
    endfunction

    function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_PLAY_MODE:    m_mode = t_play_mode'(data[2:0]);
            CFG_VEL_SETS_VOL: m_vel_vol = data[0];
            CFG_STOP_ON_HALT: m_stop_halt = data[0];
            CFG_REC_AS_LOOPS: m_rec_loops = data[0];
            CFG_SAMPLE_BEGIN: m_begin = data[POS_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic void kill_channel(logic [FRAME_W-1:0] frame);
        ch_status = ST_OFF;
        fx_pos_reset = 1'b1;
        if (frame != '0) begin
            fx_clear = 1'b1;
            fx_clear_from = frame;
        end
    endfunction

    // Rewind drops any pending action; an idle channel just resets position
    function automatic void rewind_channel(logic [FRAME_W-1:0] frame);
        ch_pending = PEND_NONE;
        if (ch_status == ST_PLAY || ch_status == ST_ENDING) begin
            ch_rewind = 1'b1;
            ch_offset = frame;
        end else begin
            fx_pos_reset = 1'b1;
        end
    endfunction

    function automatic void press_key(logic [FRAME_W-1:0] frame, logic [VEL_W-1:0] vel,
                                      logic manual, logic canq);
        case (ch_status)
            ST_OFF: begin
                ch_offset = frame;
                if (is_loop_mode()) begin
                    ch_status = ST_WAIT;
                end else begin
                    if (m_vel_vol) begin
                        fx_vol_valid = 1'b1;
                        fx_volume = VOL_W'((32'(vel) * 32'd32768) / 32'd127);
                    end
                    if (canq && manual) ch_pending = PEND_PLAY;
                    else ch_status = ST_PLAY;
                end
            end
            ST_PLAY: begin
                if (m_mode == MODE_SINGLE_RETRIG) begin
                    if (canq && manual) ch_pending = PEND_REWIND;
                    else rewind_channel(frame);
                    ch_status = ST_PLAY;
                end else if (is_loop_mode() || m_mode == MODE_SINGLE_ENDLESS) begin
                    ch_status = ST_ENDING;
                end else begin
                    if (m_mode == MODE_SINGLE_BASIC) rewind_channel(frame);
                    ch_status = ST_OFF;
                end
            end
            ST_WAIT: ch_status = ST_OFF;
            default: ch_status = ST_PLAY;
        endcase
    endfunction

    function automatic void release_key(logic [FRAME_W-1:0] frame);
        if (m_mode != MODE_SINGLE_PRESS) return;
        if (ch_status == ST_PLAY) kill_channel(frame);
        else ch_pending = PEND_NONE;
    endfunction

    // Advance the channel model by one event and build its result beat
    function automatic t_out_item next_channel_result(t_in_item it);
        t_out_item          res;
        logic [FRAME_W-1:0] frame;
        logic               loop_m;
        frame = it.frame_delta & FRAME_MASK;
        loop_m = is_loop_mode();
        ch_rewind = 1'b0;
        fx_pos_reset = 1'b0;
        fx_vol_valid = 1'b0;
        fx_volume = '0;
        fx_clear = 1'b0;
        fx_clear_from = '0;

        case (it.operation)
            OP_PRESS:   press_key(frame, it.velocity, 1'b1, it.can_quantize);
            OP_RELEASE: release_key(frame);
            OP_KILL:    kill_channel(frame);
            OP_FIRST_BEAT: begin
                if (it.clock_running) begin
                    if (ch_status == ST_PLAY) begin
                        if (loop_m) rewind_channel(frame);
                    end else if (ch_status == ST_WAIT) begin
                        ch_offset = frame;
                        ch_status = ST_PLAY;
                    end else if (ch_status == ST_ENDING) begin
                        if (loop_m) kill_channel(frame);
                    end
                end
            end
            OP_BAR: begin
                if (ch_status == ST_PLAY && m_mode == MODE_LOOP_REPEAT) begin
                    rewind_channel(frame);
                end else if (ch_status == ST_WAIT && m_mode == MODE_LOOP_ONCE_BAR) begin
                    ch_status = ST_PLAY;
                    ch_offset = frame;
                end
            end
            OP_SEQ_STOP: begin
                if (ch_status == ST_WAIT) begin
                    if (loop_m) ch_status = ST_OFF;
                end else if (ch_status == ST_PLAY) begin
                    if (m_stop_halt && (loop_m || it.reading_actions)) kill_channel('0);
                end
            end
            OP_REC_ON: begin
                if (it.reading_actions && !loop_m)
                    press_key(frame, 7'd127, 1'b0, it.can_quantize);
            end
            OP_REC_OFF: begin
                if (it.reading_actions && !loop_m) release_key(frame);
            end
            OP_REC_KILL: begin
                if (it.reading_actions && !loop_m) kill_channel(frame);
            end
            OP_TOGGLE: begin
                if (it.clock_running && it.recording_playing && !m_rec_loops)
                    kill_channel('0);
            end
            OP_LAST_FRAME: begin
                if (ch_status == ST_PLAY) begin
                    if (m_mode == MODE_SINGLE_BASIC || m_mode == MODE_SINGLE_PRESS ||
                        m_mode == MODE_SINGLE_RETRIG || (loop_m && !it.clock_running))
                        ch_status = ST_OFF;
                    else if (m_mode == MODE_LOOP_ONCE || m_mode == MODE_LOOP_ONCE_BAR)
                        ch_status = ST_WAIT;
                end else if (ch_status == ST_ENDING) begin
                    if (m_mode == MODE_LOOP_ONCE || m_mode == MODE_LOOP_ONCE_BAR)
                        ch_status = ST_WAIT;
                    else
                        ch_status = ST_OFF;
                end
            end
            OP_QUANT_FIRE: begin
                if (ch_pending == PEND_PLAY) begin
                    ch_pending = PEND_NONE;
                    ch_offset = frame;
                    ch_status = ST_PLAY;
                end else if (ch_pending == PEND_REWIND) begin
                    rewind_channel(frame);
                end else begin
                    ch_pending = PEND_NONE;
                end
            end
            default: ;  // unknown codes leave state alone
        endcase

        res.play_status    = ch_status;
        res.start_offset   = ch_offset;
        res.rewind_pending = ch_rewind;
        res.position_reset = fx_pos_reset;
        res.reset_position = fx_pos_reset ? (m_begin & POS_MASK) : '0;
        res.volume_valid   = fx_vol_valid;
        res.volume         = fx_volume;
        res.clear_buffer   = fx_clear;
        res.clear_from     = fx_clear_from;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Mismatch reporting and result comparison
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
        err_count++;
    endtask

    task automatic check_result(t_out_item got);
        t_out_item want;
        if (predicted_beats.size() == 0) begin
            report_mismatch("result beat with nothing expected", 32'(got.play_status), 0);
            return;
        end
        want = predicted_beats.pop_front();
        if (got.play_status !== want.play_status)
            report_mismatch("play_status", 32'(got.play_status), 32'(want.play_status));
        if (got.start_offset !== want.start_offset)
            report_mismatch("start_offset", 32'(got.start_offset), 32'(want.start_offset));
        if (got.rewind_pending !== want.rewind_pending)
            report_mismatch("rewind_pending", 32'(got.rewind_pending),
                            32'(want.rewind_pending));
        if (got.position_reset !== want.position_reset)
            report_mismatch("position_reset", 32'(got.position_reset),
                            32'(want.position_reset));
        if (got.reset_position !== want.reset_position)
            report_mismatch("reset_position", 32'(got.reset_position),
                            32'(want.reset_position));
        if (got.volume_valid !== want.volume_valid)
            report_mismatch("volume_valid", 32'(got.volume_valid), 32'(want.volume_valid));
        if (got.volume !== want.volume)
            report_mismatch("volume", 32'(got.volume), 32'(want.volume));
        if (got.clear_buffer !== want.clear_buffer)
            report_mismatch("clear_buffer", 32'(got.clear_buffer), 32'(want.clear_buffer));
        if (got.clear_from !== want.clear_from)
            report_mismatch("clear_from", 32'(got.clear_from), 32'(want.clear_from));
    endtask

    // ------------------------------------------------------------------
    // Idle lengths: mostly short, a few long, with calm stretches
    // ------------------------------------------------------------------
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    int send_calm = 0;

    function automatic int next_send_gap();
        if (send_calm > 0) begin
            send_calm--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            send_calm = $urandom_range(20, 60);
            return 0;
        end
        return ($urandom_range(0, 1) == 0) ? 0 : idle_len();
    endfunction

    // ------------------------------------------------------------------
    // Driver: event beats and register writes from the command queue
    // ------------------------------------------------------------------
    int send_gap = 0;
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        logic next_valid;
        logic next_cfg;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_cfg_valid <= 1'b0;
            idle_cycles = 0;
        end else begin
            next_valid = i_in_valid;
            next_cfg = i_cfg_valid;
            if (predicted_beats.size() == 0 && !i_in_valid) idle_cycles++;
            else idle_cycles = 0;

            // Beat taken this edge
            if (i_in_valid && !o_in_stall) begin
                predicted_beats.push_back(next_channel_result(i_in_data));
                next_valid = 1'b0;
                send_gap = next_send_gap();
            end
            if (i_cfg_valid && o_cfg_ready) begin
                apply_cfg(i_cfg_index, i_cfg_data);
                next_cfg = 1'b0;
            end

            // Launch the next command
            if (!next_valid && !next_cfg) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (cmd_q.size() > 0) begin
                    case (cmd_q[0].kind)
                        CMD_EVENT: begin
                            i_in_data <= cmd_q[0].beat;
                            next_valid = 1'b1;
                            void'(cmd_q.pop_front());
                        end
                        CMD_CFG: begin
                            if (idle_cycles >= CFG_SETTLE) begin
                                i_cfg_index <= cmd_q[0].idx;
                                i_cfg_data <= cmd_q[0].data;
                                next_cfg = 1'b1;
                                void'(cmd_q.pop_front());
                            end
                        end
                        default: begin
                            if (predicted_beats.size() == 0) void'(cmd_q.pop_front());
                        end
                    endcase
                end
            end
            i_in_valid <= next_valid;
            i_cfg_valid <= next_cfg;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random stall on the result side, check every taken beat
    // ------------------------------------------------------------------
    int stall_left = 0;
    int recv_calm = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) check_result(o_out_data);
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
                if (recv_calm > 0) begin
                    recv_calm--;
                end else if ($urandom_range(0, 99) < 2) begin
                    recv_calm = $urandom_range(30, 100);
                end else if ($urandom_range(0, 99) < 25) begin
                    stall_left = idle_len();
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void push_event(logic [3:0] op, logic [FRAME_W-1:0] frame,
                                       logic [VEL_W-1:0] vel, logic run, logic canq,
                                       logic rd, logic recp);
        t_cmd c;
        c.kind = CMD_EVENT;
        c.beat.operation = op;
        c.beat.frame_delta = frame;
        c.beat.velocity = vel;
        c.beat.clock_running = run;
        c.beat.can_quantize = canq;
        c.beat.reading_actions = rd;
        c.beat.recording_playing = recp;
        c.idx = '0;
        c.data = '0;
        cmd_q.push_back(c);
    endfunction

    function automatic void push_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        t_cmd c;
        c.kind = CMD_CFG;
        c.beat = '0;
        c.idx = idx;
        c.data = data;
        cmd_q.push_back(c);
    endfunction

    function automatic void push_drain();
        t_cmd c;
        c.kind = CMD_DRAIN;
        c.beat = '0;
        c.idx = '0;
        c.data = '0;
        cmd_q.push_back(c);
    endfunction

    // Random event with the given operation; frames and velocity lean to extremes
    function automatic void push_random(logic [3:0] op, logic force_run);
        int               r;
        logic [FRAME_W-1:0] frame;
        logic [VEL_W-1:0]   vel;
        r = $urandom_range(0, 9);
        frame = (r == 0) ? '0 : (r == 1) ? FRAME_MASK : FRAME_W'($urandom_range(0, 4095));
        r = $urandom_range(0, 9);
        vel = (r == 0) ? '0 : (r == 1) ? 7'd127 : VEL_W'($urandom_range(0, 127));
        push_event(op, frame, vel,
                   force_run || ($urandom_range(0, 9) < 8),
                   $urandom_range(0, 9) < 4,
                   $urandom_range(0, 9) < 6,
                   1'($urandom_range(0, 1)));
    endfunction

    // ------------------------------------------------------------------
    // Stimulus plan, reset, end of run
    // ------------------------------------------------------------------
    initial begin
        int         sent;
        int         n_tail;
        logic [3:0] noise_op;

        // Directed: single basic with velocity volume
        push_cfg(CFG_VEL_SETS_VOL, 24'd1);
        push_event(OP_PRESS, 12'd0, 7'd127, 1, 0, 0, 0);       // off to play, full volume
        push_event(OP_PRESS, 12'd4095, 7'd5, 1, 0, 0, 0);      // rewind then off
        push_event(OP_PRESS, 12'd33, 7'd0, 1, 1, 0, 0);        // quantized play, zero volume
        push_event(OP_QUANT_FIRE, 12'd100, 7'd0, 1, 1, 0, 0);  // pending play fires
        push_event(OP_KILL, 12'd0, 7'd0, 1, 0, 0, 0);          // kill at frame zero
        push_event(OP_KILL, 12'd4095, 7'd0, 1, 0, 0, 0);       // kill with buffer clear
        push_event(4'd15, 12'd4095, 7'd127, 1, 1, 1, 1);       // unknown code
        push_event(OP_QUANT_FIRE, 12'd9, 7'd0, 1, 1, 0, 0);    // nothing pending
        // Retrigger: pending rewind survives a kill, fires on an idle channel
        push_cfg(CFG_PLAY_MODE, 24'(MODE_SINGLE_RETRIG));
        push_event(OP_PRESS, 12'd1, 7'd64, 1, 0, 0, 0);
        push_event(OP_PRESS, 12'd2, 7'd64, 1, 1, 0, 0);
        push_event(OP_KILL, 12'd7, 7'd0, 1, 0, 0, 0);
        push_event(OP_QUANT_FIRE, 12'd8, 7'd0, 1, 1, 0, 0);
        // Loop repeat with maximum sample begin
        push_cfg(CFG_PLAY_MODE, 24'(MODE_LOOP_REPEAT));
        push_cfg(CFG_SAMPLE_BEGIN, 24'hFFFFFF);
        push_event(OP_PRESS, 12'd10, 7'd1, 1, 0, 0, 0);        // off to wait
        push_event(OP_FIRST_BEAT, 12'd20, 7'd0, 0, 0, 0, 0);   // clock stopped: ignored
        push_event(OP_FIRST_BEAT, 12'd30, 7'd0, 1, 0, 0, 0);   // wait to play
        push_event(OP_BAR, 12'd40, 7'd0, 1, 0, 0, 0);          // bar rewind
        push_event(OP_SEQ_STOP, 12'd50, 7'd0, 1, 0, 0, 0);     // stop kills loop
        // Single press with recorded actions
        push_cfg(CFG_PLAY_MODE, 24'(MODE_SINGLE_PRESS));
        push_cfg(CFG_REC_AS_LOOPS, 24'd0);
        push_event(OP_REC_ON, 12'd60, 7'd3, 1, 1, 1, 0);       // recorded press, velocity 127
        push_event(OP_REC_OFF, 12'd70, 7'd0, 1, 0, 1, 0);      // release kills
        push_event(OP_REC_ON, 12'd80, 7'd0, 1, 0, 0, 0);       // not reading: ignored
        push_event(OP_PRESS, 12'd90, 7'd77, 1, 0, 0, 0);
        push_event(OP_TOGGLE, 12'd0, 7'd0, 1, 0, 1, 1);        // toggle kills
        push_event(OP_REC_KILL, 12'd5, 7'd0, 1, 0, 1, 0);
        push_event(OP_LAST_FRAME, 12'd0, 7'd0, 1, 0, 0, 0);
        push_drain();

        // Random phases, each with its own setting of every register
        for (int ph = 0; ph < 14; ph++) begin
            push_cfg(CFG_PLAY_MODE, (ph < 8) ? 24'(ph) : 24'($urandom_range(0, 7)));
            push_cfg(CFG_VEL_SETS_VOL, 24'($urandom_range(0, 1)));
            push_cfg(CFG_STOP_ON_HALT, 24'($urandom_range(0, 1)));
            push_cfg(CFG_REC_AS_LOOPS, 24'($urandom_range(0, 1)));
            case (ph % 3)
                0:       push_cfg(CFG_SAMPLE_BEGIN, 24'd0);
                1:       push_cfg(CFG_SAMPLE_BEGIN, 24'hFFFFFF);
                default: push_cfg(CFG_SAMPLE_BEGIN, 24'($urandom_range(0, 24'hFFFFFF)));
            endcase
            sent = 0;
            while (sent < 60) begin
                if (sent >= 30 && sent < 36 && ph % 2 == 1) push_drain();
                if ($urandom_range(0, 99) < 55) begin
                    // A take: press, quantize, beat, bar, then a few follow-ups
                    push_random(OP_PRESS, 0);
                    push_random(OP_QUANT_FIRE, 0);
                    push_random(OP_FIRST_BEAT, 1);
                    push_random(OP_BAR, 0);
                    sent += 4;
                    n_tail = $urandom_range(1, 3);
                    for (int k = 0; k < n_tail; k++) begin
                        case ($urandom_range(0, 5))
                            0:       push_random(OP_LAST_FRAME, 0);
                            1:       push_random(OP_PRESS, 0);
                            2:       push_random(OP_RELEASE, 0);
                            3:       push_random(OP_REC_ON, 0);
                            4:       push_random(OP_REC_OFF, 0);
                            default: push_random(OP_SEQ_STOP, 0);
                        endcase
                    end
                    sent += n_tail;
                end else begin
                    noise_op = ($urandom_range(0, 99) < 90) ? 4'($urandom_range(0, 11))
                                                            : 4'($urandom_range(12, 15));
                    push_random(noise_op, 0);
                    sent++;
                end
            end
        end

        // Reset once, then let the driver run
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_q.size() != 0 || i_in_valid || i_cfg_valid || predicted_beats.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (predicted_beats.size() != 0)
            report_mismatch("expected beats never arrived", 32'(predicted_beats.size()), 0);
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #1000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: sample_channel_play_control_core.f
src/scpc_pkg.sv
src/scpc_cfg_regs.sv
src/scpc_event_core.sv
src/sample_channel_play_control_core.sv
src/scpc_checker.sv
verif/tb_sample_channel_play_control_core.sv
